>>> rtl/cbe_pkg.sv
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared constants, register indexes and types of the cubic Bezier easing core.
// ----------------------------------------------------------------------------
package cbe_pkg;

    // fixed-point format and bisection cap
    localparam int FRAC_BITS = 16;
    localparam int MAX_STEPS = 24;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    // field widths
    localparam int X_W   = FRAC_BITS + 1;      // unsigned 0..1 values
    localparam int T_W   = FRAC_BITS + 3;      // signed time and y fields
    localparam int Q_W   = FRAC_BITS + 1;      // truncated products, 0..1
    localparam int C_W   = T_W + 2;            // three times a control coordinate
    localparam int MUL_W = C_W + Q_W + 1;      // product of the shared multiplier
    localparam int BEZ_W = T_W + 5;            // curve value before masking
    localparam int DIFF_W = BEZ_W + 1;

    localparam logic [X_W-1:0] ONE = X_W'(1) << FRAC_BITS;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = T_W;

    localparam logic [CFG_IDX_W-1:0] REG_CTRL1_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL1_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL2_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL2_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_BOUND = 3'd4;

    // register reset values
    localparam logic [X_W-1:0]        RST_CTRL1_X     = X_W'(16384);
    localparam logic signed [T_W-1:0] RST_CTRL1_Y     = T_W'(0);
    localparam logic [X_W-1:0]        RST_CTRL2_X     = X_W'(49152);
    localparam logic signed [T_W-1:0] RST_CTRL2_Y     = T_W'(65536);
    localparam logic [X_W-1:0]        RST_ERROR_BOUND = X_W'(66);

    // request to the curve evaluator
    typedef struct packed {
        logic                    start;
        logic [X_W-1:0]          m;
        logic signed [C_W-1:0]   c1;
        logic signed [C_W-1:0]   c2;
    } t_bez_req;

    // answer from the curve evaluator
    typedef struct packed {
        logic                    done;
        logic signed [BEZ_W-1:0] res;
    } t_bez_rsp;

endpackage

>>> rtl/cbe_if.sv
// ----------------------------------------------------------------------------
// cbe interfaces
// Valid/ready channels for time beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface cbe_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [cbe_pkg::T_W-1:0]     time_in;

    modport source (output valid, output time_in, input ready);
    modport sink   (input valid, input time_in, output ready);
endinterface

interface cbe_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [cbe_pkg::T_W-1:0]     eased_value;
    logic                               out_of_range;

    modport source (output valid, output eased_value, output out_of_range, input ready);
    modport sink   (input valid, input eased_value, input out_of_range, output ready);
endinterface

interface cbe_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [cbe_pkg::CFG_IDX_W-1:0]      index;
    logic [cbe_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/cubic_bezier_easing_core.sv
// ----------------------------------------------------------------------------
// cubic_bezier_easing_core
// Cubic Bezier easing curve with end points (0,0) and (1,1), Q16 in and out.
//
// Each time beat is answered by one result beat. A time outside 0..1.0 gives
// 1.0 with out_of_range set. Otherwise the curve parameter is bisected on
// 0..1 until the x value lies within error_bound of the time, at most 24
// midpoints, and y is evaluated at the last midpoint. Every curve evaluation
// runs eight products through one shared multiplier. The input is not ready
// while an item is being worked on; a finished result waits in the output
// register and does not hold off the next time beat. The user must write
// registers over the configuration channel only while the core is idle; the
// core itself does not enforce this. Indexes past the list are ignored.
// ----------------------------------------------------------------------------
module cubic_bezier_easing_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbe_in_if.sink      i_in,
    cbe_out_if.source   o_out,
    cbe_cfg_if.sink     i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MID,
        S_XWAIT,
        S_YWAIT,
        S_PUT
    } t_state;

    t_state                                 r_state;

    // configuration registers
    logic [cbe_pkg::X_W-1:0]                r_ctrl1_x;
    logic signed [cbe_pkg::T_W-1:0]         r_ctrl1_y;
    logic [cbe_pkg::X_W-1:0]                r_ctrl2_x;
    logic signed [cbe_pkg::T_W-1:0]         r_ctrl2_y;
    logic [cbe_pkg::X_W-1:0]                r_bound;

    // bisection state
    logic signed [cbe_pkg::T_W-1:0]         r_t;
    logic [cbe_pkg::X_W-1:0]                r_lo;
    logic [cbe_pkg::X_W-1:0]                r_hi;
    logic [cbe_pkg::X_W-1:0]                r_mid;
    logic [cbe_pkg::STEP_W-1:0]             r_step;

    // result waiting for the output register
    logic signed [cbe_pkg::T_W-1:0]         r_res_y;
    logic                                   r_res_oor;

    // output register
    logic                                   r_out_valid;
    logic signed [cbe_pkg::T_W-1:0]         r_y;
    logic                                   r_oor;

    cbe_pkg::t_bez_req                      w_req;
    cbe_pkg::t_bez_rsp                      w_rsp;

    logic [cbe_pkg::X_W:0]                  w_sum;
    logic [cbe_pkg::X_W-1:0]                w_mid;
    logic signed [cbe_pkg::C_W-1:0]         w_cx1;
    logic signed [cbe_pkg::C_W-1:0]         w_cx2;
    logic signed [cbe_pkg::C_W-1:0]         w_cy1;
    logic signed [cbe_pkg::C_W-1:0]         w_cy2;
    logic signed [cbe_pkg::DIFF_W-1:0]      w_diff;
    logic [cbe_pkg::DIFF_W-1:0]             w_dist;
    logic                                   w_found;
    logic                                   w_last;
    logic                                   w_t_bad;
    logic                                   w_in_beat;
    logic                                   w_put;

    cbe_bez u_bez (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_beat   = i_in.valid && (r_state == S_IDLE);
    assign w_put       = (r_state == S_PUT) && (!r_out_valid || o_out.ready);

    assign o_out.valid        = r_out_valid;
    assign o_out.eased_value  = r_y;
    assign o_out.out_of_range = r_oor;

    // time outside 0..1.0
    assign w_t_bad = i_in.time_in[cbe_pkg::T_W-1]
                     || (i_in.time_in > signed'(cbe_pkg::T_W'(cbe_pkg::ONE)));

    // midpoint, truncated
    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_sum[cbe_pkg::X_W:1];

    // control coordinates times three
    assign w_cx1 = signed'(cbe_pkg::C_W'(r_ctrl1_x)) + (signed'(cbe_pkg::C_W'(r_ctrl1_x)) <<< 1);
    assign w_cx2 = signed'(cbe_pkg::C_W'(r_ctrl2_x)) + (signed'(cbe_pkg::C_W'(r_ctrl2_x)) <<< 1);
    assign w_cy1 = cbe_pkg::C_W'(r_ctrl1_y) + (cbe_pkg::C_W'(r_ctrl1_y) <<< 1);
    assign w_cy2 = cbe_pkg::C_W'(r_ctrl2_y) + (cbe_pkg::C_W'(r_ctrl2_y) <<< 1);

    // distance of the x estimate from the time
    assign w_diff  = cbe_pkg::DIFF_W'(w_rsp.res) - cbe_pkg::DIFF_W'(r_t);
    assign w_dist  = w_diff[cbe_pkg::DIFF_W-1] ? unsigned'(-w_diff) : unsigned'(w_diff);
    assign w_found = (w_dist <= cbe_pkg::DIFF_W'(r_bound));
    assign w_last  = (r_step == cbe_pkg::STEP_W'(cbe_pkg::MAX_STEPS));

    // evaluator requests: x at a new midpoint, or y at the final one
    always_comb begin
        w_req.start = 1'b0;
        w_req.m     = w_mid;
        w_req.c1    = w_cx1;
        w_req.c2    = w_cx2;
        case (r_state)
            S_MID: begin
                w_req.start = 1'b1;
            end
            S_XWAIT: begin
                w_req.m  = r_mid;
                w_req.c1 = w_cy1;
                w_req.c2 = w_cy2;
                if (w_rsp.done && (w_found || w_last)) begin
                    w_req.start = 1'b1;
                end
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl1_x <= cbe_pkg::RST_CTRL1_X;
            r_ctrl1_y <= cbe_pkg::RST_CTRL1_Y;
            r_ctrl2_x <= cbe_pkg::RST_CTRL2_X;
            r_ctrl2_y <= cbe_pkg::RST_CTRL2_Y;
            r_bound   <= cbe_pkg::RST_ERROR_BOUND;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                cbe_pkg::REG_CTRL1_X:     r_ctrl1_x <= i_cfg.data[cbe_pkg::X_W-1:0];
                cbe_pkg::REG_CTRL1_Y:     r_ctrl1_y <= signed'(i_cfg.data);
                cbe_pkg::REG_CTRL2_X:     r_ctrl2_x <= i_cfg.data[cbe_pkg::X_W-1:0];
                cbe_pkg::REG_CTRL2_Y:     r_ctrl2_y <= signed'(i_cfg.data);
                cbe_pkg::REG_ERROR_BOUND: r_bound   <= i_cfg.data[cbe_pkg::X_W-1:0];
                default: ;
            endcase
        end
    end

    // bisection sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && !w_put) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_beat) begin
                        r_t    <= i_in.time_in;
                        r_lo   <= '0;
                        r_hi   <= cbe_pkg::ONE;
                        r_step <= '0;
                        if (w_t_bad) begin
                            r_res_y   <= signed'(cbe_pkg::T_W'(cbe_pkg::ONE));
                            r_res_oor <= 1'b1;
                            r_state   <= S_PUT;
                        end else begin
                            r_state <= S_MID;
                        end
                    end
                end
                S_MID: begin
                    r_mid   <= w_mid;
                    r_step  <= r_step + 1'b1;
                    r_state <= S_XWAIT;
                end
                S_XWAIT: begin
                    if (w_rsp.done) begin
                        if (w_found || w_last) begin
                            r_state <= S_YWAIT;
                        end else begin
                            if (w_diff[cbe_pkg::DIFF_W-1]) begin
                                r_lo <= r_mid;
                            end else begin
                                r_hi <= r_mid;
                            end
                            r_state <= S_MID;
                        end
                    end
                end
                S_YWAIT: begin
                    if (w_rsp.done) begin
                        r_res_y   <= w_rsp.res[cbe_pkg::T_W-1:0];
                        r_res_oor <= 1'b0;
                        r_state   <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (w_put) begin
                        r_y         <= r_res_y;
                        r_oor       <= r_res_oor;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/cbe_mul.sv
// ----------------------------------------------------------------------------
// cbe_mul
// Shared signed by unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module cbe_mul (
    input  logic                                 i_clk,
    input  logic signed [cbe_pkg::C_W-1:0]       i_a,
    input  logic        [cbe_pkg::Q_W-1:0]       i_b,
    output logic signed [cbe_pkg::MUL_W-1:0]     o_p
);

    // one product per cycle, unsigned operand taken as positive
    always_ff @(posedge i_clk) begin
        o_p <= cbe_pkg::MUL_W'(i_a) * cbe_pkg::MUL_W'(signed'({1'b0, i_b}));
    end

endmodule

>>> rtl/cbe_bez.sv
// ----------------------------------------------------------------------------
// cbe_bez
// Sequencer that evaluates c1*(1-m)^2*m + c2*(1-m)*m^2 + m^3 on the
// shared multiplier, one product issued per cycle.
// ----------------------------------------------------------------------------
module cbe_bez (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cbe_pkg::t_bez_req    i_req,
    output cbe_pkg::t_bez_rsp    o_rsp
);

    // PH_UM..PH_B issue one product each and store the one issued before
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_UU,
        PH_UM,
        PH_MM,
        PH_P1,
        PH_P2,
        PH_P3,
        PH_A,
        PH_B,
        PH_SUM,
        PH_RES
    } t_phase;

    t_phase                              r_ph;
    logic [cbe_pkg::X_W-1:0]             r_m;
    logic [cbe_pkg::X_W-1:0]             r_u;
    logic signed [cbe_pkg::C_W-1:0]      r_c1;
    logic signed [cbe_pkg::C_W-1:0]      r_c2;
    logic [cbe_pkg::Q_W-1:0]             r_uu;
    logic [cbe_pkg::Q_W-1:0]             r_um;
    logic [cbe_pkg::Q_W-1:0]             r_mm;
    logic [cbe_pkg::Q_W-1:0]             r_p1;
    logic [cbe_pkg::Q_W-1:0]             r_p2;
    logic [cbe_pkg::Q_W-1:0]             r_p3;
    logic signed [cbe_pkg::MUL_W-1:0]    r_acc;
    logic signed [cbe_pkg::BEZ_W-1:0]    r_res;
    logic                                r_done;

    logic signed [cbe_pkg::C_W-1:0]      w_a;
    logic [cbe_pkg::Q_W-1:0]             w_b;
    logic signed [cbe_pkg::MUL_W-1:0]    w_prod;
    logic [cbe_pkg::Q_W-1:0]             w_q;

    cbe_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_prod)
    );

    // product truncated back to the fraction format
    assign w_q = w_prod[cbe_pkg::FRAC_BITS +: cbe_pkg::Q_W];

    // operand selection per phase
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_ph)
            PH_UU: begin
                w_a = signed'(cbe_pkg::C_W'(r_u));
                w_b = r_u;
            end
            PH_UM: begin
                w_a = signed'(cbe_pkg::C_W'(r_u));
                w_b = r_m;
            end
            PH_MM: begin
                w_a = signed'(cbe_pkg::C_W'(r_m));
                w_b = r_m;
            end
            PH_P1: begin
                w_a = signed'(cbe_pkg::C_W'(r_uu));
                w_b = r_m;
            end
            PH_P2: begin
                w_a = signed'(cbe_pkg::C_W'(r_um));
                w_b = r_m;
            end
            PH_P3: begin
                w_a = signed'(cbe_pkg::C_W'(r_mm));
                w_b = r_m;
            end
            PH_A: begin
                w_a = r_c1;
                w_b = r_p1;
            end
            PH_B: begin
                w_a = r_c2;
                w_b = r_p2;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // phase sequencer and partial results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_ph)
                PH_IDLE: begin
                    if (i_req.start) begin
                        r_m  <= i_req.m;
                        r_u  <= cbe_pkg::ONE - i_req.m;
                        r_c1 <= i_req.c1;
                        r_c2 <= i_req.c2;
                        r_ph <= PH_UU;
                    end
                end
                PH_UU:  r_ph <= PH_UM;
                PH_UM: begin
                    r_uu <= w_q;
                    r_ph <= PH_MM;
                end
                PH_MM: begin
                    r_um <= w_q;
                    r_ph <= PH_P1;
                end
                PH_P1: begin
                    r_mm <= w_q;
                    r_ph <= PH_P2;
                end
                PH_P2: begin
                    r_p1 <= w_q;
                    r_ph <= PH_P3;
                end
                PH_P3: begin
                    r_p2 <= w_q;
                    r_ph <= PH_A;
                end
                PH_A: begin
                    r_p3 <= w_q;
                    r_ph <= PH_B;
                end
                PH_B: begin
                    r_acc <= w_prod;
                    r_ph  <= PH_SUM;
                end
                PH_SUM: begin
                    r_acc <= r_acc + w_prod;
                    r_ph  <= PH_RES;
                end
                PH_RES: begin
                    // floor shift of the weighted sum, then the cube term
                    r_res  <= cbe_pkg::BEZ_W'(r_acc >>> cbe_pkg::FRAC_BITS)
                              + cbe_pkg::BEZ_W'(r_p3);
                    r_done <= 1'b1;
                    r_ph   <= PH_IDLE;
                end
                default: r_ph <= PH_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

>>> bench/cbe_ease_checker.sv
// ----------------------------------------------------------------------------
// cbe_ease_checker
// Watches the time, result and register channels of the easing core. Keeps
// its own copy of the registers, bisects the curve for each accepted time
// beat in range and compares each result beat with the oldest pending answer.
// ----------------------------------------------------------------------------
module cbe_ease_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    cbe_in_if    i_time,
    cbe_out_if   i_ease,
    cbe_cfg_if   i_cfg,
    output int   o_mismatches,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [cbe_pkg::T_W-1:0] value;
        logic                           oor;
    } t_eased;

    // shadow of the curve registers
    logic [cbe_pkg::X_W-1:0]        c1_x;
    logic signed [cbe_pkg::T_W-1:0] c1_y;
    logic [cbe_pkg::X_W-1:0]        c2_x;
    logic signed [cbe_pkg::T_W-1:0] c2_y;
    logic [cbe_pkg::X_W-1:0]        err_bound;

    t_eased eased_due[$];
    int     bad_beats;

    localparam longint ONE_L = longint'(cbe_pkg::ONE);

    // one coordinate of the curve at parameter m, truncated products
    function automatic longint curve_point(longint c1, longint c2, longint m);
        longint u;
        longint p1;
        longint p2;
        longint p3;
        longint acc;
        u   = ONE_L - m;
        p1  = (((u * u) >>> cbe_pkg::FRAC_BITS) * m) >>> cbe_pkg::FRAC_BITS;
        p2  = (((u * m) >>> cbe_pkg::FRAC_BITS) * m) >>> cbe_pkg::FRAC_BITS;
        p3  = (((m * m) >>> cbe_pkg::FRAC_BITS) * m) >>> cbe_pkg::FRAC_BITS;
        acc = 3 * c1 * p1 + 3 * c2 * p2;
        // arithmetic shift of a signed value rounds toward minus infinity
        return (acc >>> cbe_pkg::FRAC_BITS) + p3;
    endfunction

    // bisect x towards the time, then read y at the last midpoint
    function automatic t_eased ease_at_time(logic signed [cbe_pkg::T_W-1:0] t_in);
        t_eased res;
        longint t;
        longint lo;
        longint hi;
        longint mid;
        longint x;
        longint d;
        longint y;
        bit     found;
        int     step;
        t = longint'(t_in);
        if (t < 0 || t > ONE_L) begin
            res.value = ONE_L[cbe_pkg::T_W-1:0];
            res.oor   = 1'b1;
            return res;
        end
        lo    = 0;
        hi    = ONE_L;
        mid   = 0;
        found = 1'b0;
        for (step = 0; step < cbe_pkg::MAX_STEPS && !found; step++) begin
            mid = (lo + hi) >> 1;
            x   = curve_point(longint'(c1_x), longint'(c2_x), mid);
            d   = (x < t) ? t - x : x - t;
            if (d <= longint'(err_bound))
                found = 1'b1;
            else if (x < t)
                lo = mid;
            else
                hi = mid;
        end
        y         = curve_point(longint'(c1_y), longint'(c2_y), mid);
        res.value = y[cbe_pkg::T_W-1:0];
        res.oor   = 1'b0;
        return res;
    endfunction

    // register writes, time beats in, result beats out
    always @(posedge i_clk) begin
        t_eased want;
        if (!i_rst_n) begin
            c1_x      = cbe_pkg::RST_CTRL1_X;
            c1_y      = cbe_pkg::RST_CTRL1_Y;
            c2_x      = cbe_pkg::RST_CTRL2_X;
            c2_y      = cbe_pkg::RST_CTRL2_Y;
            err_bound = cbe_pkg::RST_ERROR_BOUND;
            eased_due.delete();
            bad_beats = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    cbe_pkg::REG_CTRL1_X:     c1_x      = i_cfg.data[cbe_pkg::X_W-1:0];
                    cbe_pkg::REG_CTRL1_Y:     c1_y      = i_cfg.data[cbe_pkg::T_W-1:0];
                    cbe_pkg::REG_CTRL2_X:     c2_x      = i_cfg.data[cbe_pkg::X_W-1:0];
                    cbe_pkg::REG_CTRL2_Y:     c2_y      = i_cfg.data[cbe_pkg::T_W-1:0];
                    cbe_pkg::REG_ERROR_BOUND: err_bound = i_cfg.data[cbe_pkg::X_W-1:0];
                    default: ;
                endcase
            end
            if (i_time.valid && i_time.ready)
                eased_due.push_back(ease_at_time(i_time.time_in));
            if (i_ease.valid && i_ease.ready) begin
                if (eased_due.size() == 0) begin
                    $display("%0t: result beat with nothing pending: value %0d oor %0b",
                             $time, i_ease.eased_value, i_ease.out_of_range);
                    bad_beats++;
                end else begin
                    want = eased_due.pop_front();
                    if (want.value !== i_ease.eased_value
                        || want.oor !== i_ease.out_of_range) begin
                        $display({"%0t: result mismatch: expected value %0d oor %0b,",
                                  " got value %0d oor %0b"},
                                 $time, want.value, want.oor,
                                 i_ease.eased_value, i_ease.out_of_range);
                        bad_beats++;
                    end
                end
            end
        end
        o_mismatches <= bad_beats;
        o_pending    <= eased_due.size();
    end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the easing core with time beats and register writes. A directed
// part covers the time extremes, out-of-range times, the step cap, immediate
// acceptance and unused register indexes; random phases follow, each with a
// fresh curve and one of three idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 60;
    localparam int HOLD_CYCLES   = 1500;
    localparam int RAND_PHASES   = 9;
    localparam int PHASE_BEATS   = 50;

    localparam logic [cbe_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [cbe_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_go = 1'b0;
    bit recv_hold = 1'b0;
    int cycle_count = 0;
    int mismatches;
    int pending;

    cbe_in_if  time_ch ();
    cbe_out_if ease_ch ();
    cbe_cfg_if cfg_ch ();

    cubic_bezier_easing_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (time_ch),
        .o_out   (ease_ch),
        .i_cfg   (cfg_ch)
    );

    cbe_ease_checker ease_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_time       (time_ch),
        .i_ease       (ease_ch),
        .i_cfg        (cfg_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[cubic_bezier_easing_core] ERROR");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            ease_ch.ready <= 1'b0;
        else if (recv_hold)
            ease_ch.ready <= 1'b0;
        else
            ease_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // one long hold-off on the result side, so the core fills and stalls
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        recv_hold <= 1'b0;
    end

    // offer a time beat, valid stays high after acceptance
    task automatic send_time(input int t);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            time_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        time_ch.valid   <= 1'b1;
        time_ch.time_in <= cbe_pkg::T_W'(t);
        do @(posedge i_clk); while (!time_ch.ready);
    endtask

    task automatic stop_sending();
        time_ch.valid <= 1'b0;
    endtask

    // wait until every pending result has come back
    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic settle();
        stop_sending();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [cbe_pkg::CFG_IDX_W-1:0] idx, input int val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= cbe_pkg::CFG_DATA_W'(val);
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic program_curve(input int c1x, input int c1y, input int c2x,
                                 input int c2y, input int bound);
        write_reg(cbe_pkg::REG_CTRL1_X, c1x);
        write_reg(cbe_pkg::REG_CTRL1_Y, c1y);
        write_reg(cbe_pkg::REG_CTRL2_X, c2x);
        write_reg(cbe_pkg::REG_CTRL2_Y, c2y);
        write_reg(cbe_pkg::REG_ERROR_BOUND, bound);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic int raw_bits(int width);
        return int'($urandom_range(0, (1 << width) - 1));
    endfunction

    // control x, now and then with every data bit random
    function automatic int pick_x();
        if ($urandom_range(0, 9) == 0)
            return raw_bits(cbe_pkg::CFG_DATA_W);
        return int'($urandom_range(0, 65536));
    endfunction

    function automatic int pick_y();
        if ($urandom_range(0, 9) == 0)
            return raw_bits(cbe_pkg::CFG_DATA_W);
        return int'($urandom_range(0, 327680)) - 131072;
    endfunction

    // mostly tight bounds, so bisection runs deep
    function automatic int pick_bound();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return raw_bits(cbe_pkg::CFG_DATA_W);
            2:       return int'($urandom_range(0, 65536));
            default: return int'($urandom_range(1, 400));
        endcase
    endfunction

    // mostly valid times, some just outside and some with every bit random
    function automatic int pick_time();
        case ($urandom_range(0, 19))
            0: return raw_bits(cbe_pkg::T_W);
            1: begin
                case ($urandom_range(0, 3))
                    0:       return -1;
                    1:       return 65537;
                    2:       return 0;
                    default: return 65536;
                endcase
            end
            2:       return int'($urandom_range(65537, 131072));
            3:       return -int'($urandom_range(1, 65536));
            default: return int'($urandom_range(0, 65536));
        endcase
    endfunction

    // stimulus
    initial begin
        int ph;
        int k;
        i_rst_n         = 1'b0;
        time_ch.valid   = 1'b0;
        time_ch.time_in = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        send_idle_pct   = 33;
        recv_idle_pct   = 63;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // writes past the register list must leave the reset curve alone
        write_reg(REG_UNUSED_LO, raw_bits(cbe_pkg::CFG_DATA_W));
        write_reg(REG_UNUSED_HI, 19'h7FFFF);
        cfg_ch.valid <= 1'b0;

        // reset curve: time extremes and out-of-range times
        send_time(0);
        send_time(65536);
        send_time(1);
        send_time(65535);
        send_time(32768);
        send_time(-1);
        send_time(65537);
        send_time(-65536);
        send_time(131072);
        send_time(262143);
        send_time(-262144);
        settle();

        // zero bound: the search ends on an exact hit or at the step cap
        program_curve(0, -131072, 65536, 196608, 0);
        send_time(0);
        send_time(65536);
        send_time(32768);
        send_time(12345);
        settle();

        // bound of one: the first midpoint is always accepted
        program_curve(65536, 196608, 0, -131072, 65536);
        send_time(0);
        send_time(65536);
        send_time(20000);
        settle();

        // every data bit set or at its extreme, control points out of range
        program_curve(19'h7FFFF, 19'h40000, 19'h7FFFF, 19'h3FFFF, 19'h7FFFF);
        send_time(0);
        send_time(40000);
        send_time(65536);
        settle();
        program_curve(0, 19'h3FFFF, 19'h20000, 19'h40000, 1);
        send_time(50000);
        send_time(7);
        settle();

        // random phases, each with its own curve and one of three idle patterns
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph / 3)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct = 63;
                end
                1: begin
                    send_idle_pct = 63;
                    recv_idle_pct = 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            program_curve(pick_x(), pick_y(), pick_x(), pick_y(), pick_bound());
            if (ph == 1)
                hold_go = 1'b1;
            for (k = 0; k < PHASE_BEATS; k++) begin
                if (ph == 4 && k == PHASE_BEATS / 2) begin
                    stop_sending();
                    wait_drained();
                end
                send_time(pick_time());
            end
            settle();
        end

        stop_sending();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("[cubic_bezier_easing_core] OK");
        else
            $display("[cubic_bezier_easing_core] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cbe_pkg.sv
rtl/cbe_if.sv
rtl/cbe_mul.sv
rtl/cbe_bez.sv
rtl/cubic_bezier_easing_core.sv
bench/cbe_ease_checker.sv
bench/tb.sv
